// ----- rtl/core/vref_pkg.sv -----
// ----------------------------------------------------------------------------
// vref_pkg
// shared constants and helpers for the vector refraction pipeline
// ----------------------------------------------------------------------------
package vref_pkg;

   // default internal fraction bits
   localparam int FRAC_BITS_DEF = 14;
   // vector components per item
   localparam int NUM_AXES = 3;
   // width of one input or output field
   localparam int FIELD_W = 16;
   // fraction bits of the normal and of the output format
   localparam int NORM_FRAC = 14;
   // fraction bits of the index ratio
   localparam int ETA_FRAC = 12;
   // width of the squared length and of the normalizing length
   localparam int L2_W = 32;
   localparam int LEN_W = 31;
   // scaling of the squared length before the root
   localparam int L2_SHIFT = 30;
   localparam int LEN_FRAC = 15;

   // arithmetic right shift by s, rounding half away from zero
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                  input int unsigned s);
      logic [63:0] m;
      logic [63:0] r;
      m = x[63] ? 64'(-x) : 64'(x);
      r = (s == 0) ? m : ((m + (64'd1 << (s - 1))) >> s);
      return x[63] ? -$signed(r) : $signed(r);
   endfunction

endpackage

// ----- rtl/core/vref_sqrt.sv -----
// ----------------------------------------------------------------------------
// vref_sqrt
// pipelined integer square root, one result bit per stage, with sideband
// ----------------------------------------------------------------------------
module vref_sqrt
   import vref_pkg::*;
#(
   parameter int IN_W   = 62,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  vld_in,
   input  logic [IN_W-1:0]       x_in,
   input  logic [SIDE_W-1:0]     side_in,
   output logic                  vld_out,
   output logic [IN_W/2-1:0]     root_out,
   output logic [SIDE_W-1:0]     side_out
);

   localparam int ST = IN_W / 2;

   logic [IN_W-1:0]   rem_ff [ST];
   logic [IN_W-1:0]   res_ff [ST];
   logic [SIDE_W-1:0] side_ff [ST];
   logic [ST-1:0]     vld_ff;

   for (genvar k = 0; k < ST; k++) begin : g_stage
      localparam logic [IN_W-1:0] BITV = IN_W'(1) << (IN_W - 2 - 2 * k);
      logic [IN_W-1:0]   rem_prev;
      logic [IN_W-1:0]   res_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              vld_prev;
      logic [IN_W-1:0]   trial;
      logic [IN_W-1:0]   rem_in;
      logic [IN_W-1:0]   res_in;

      if (k == 0) begin : g_first
         assign rem_prev  = x_in;
         assign res_prev  = '0;
         assign side_prev = side_in;
         assign vld_prev  = vld_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign res_prev  = res_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // one restoring step
      always_comb begin
         trial = res_prev + BITV;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BITV;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      // stage payload
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_prev;
         end
      end

      // stage valid
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end
   end

   assign vld_out  = vld_ff[ST-1];
   assign root_out = res_ff[ST-1][ST-1:0];
   assign side_out = side_ff[ST-1];

endmodule

// ----- rtl/core/vref_div.sv -----
// ----------------------------------------------------------------------------
// vref_div
// pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor
// ----------------------------------------------------------------------------
module vref_div
   import vref_pkg::*;
#(
   parameter int NUM_W  = 46,
   parameter int DEN_W  = 31,
   parameter int Q_W    = 16,
   parameter int SIDE_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               vld_in,
   input  logic [NUM_AXES-1:0][NUM_W-1:0]     num_in,
   input  logic [DEN_W-1:0]                   den_in,
   input  logic [SIDE_W-1:0]                  side_in,
   output logic                               vld_out,
   output logic [NUM_AXES-1:0][Q_W-1:0]       quo_out,
   output logic [SIDE_W-1:0]                  side_out
);

   logic [NUM_AXES-1:0][NUM_W-1:0] rem_ff [Q_W];
   logic [NUM_AXES-1:0][Q_W-1:0]   quo_ff [Q_W];
   logic [DEN_W-1:0]               den_ff [Q_W];
   logic [SIDE_W-1:0]              side_ff [Q_W];
   logic [Q_W-1:0]                 vld_ff;

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [NUM_AXES-1:0][NUM_W-1:0] rem_prev;
      logic [NUM_AXES-1:0][Q_W-1:0]   quo_prev;
      logic [DEN_W-1:0]               den_prev;
      logic [SIDE_W-1:0]              side_prev;
      logic                           vld_prev;
      logic [NUM_W-1:0]               dsh;
      logic [NUM_AXES-1:0][NUM_W-1:0] rem_in;
      logic [NUM_AXES-1:0][Q_W-1:0]   quo_in;

      if (k == 0) begin : g_first
         assign rem_prev  = num_in;
         assign quo_prev  = '0;
         assign den_prev  = den_in;
         assign side_prev = side_in;
         assign vld_prev  = vld_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // compare and subtract the shifted divisor in each lane
      always_comb begin
         dsh = NUM_W'(den_prev) << (Q_W - 1 - k);
         for (int i = 0; i < NUM_AXES; i++) begin
            if (rem_prev[i] >= dsh) begin
               rem_in[i] = rem_prev[i] - dsh;
               quo_in[i] = {quo_prev[i][Q_W-2:0], 1'b1};
            end else begin
               rem_in[i] = rem_prev[i];
               quo_in[i] = {quo_prev[i][Q_W-2:0], 1'b0};
            end
         end
      end

      // stage payload
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end

      // stage valid
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end
   end

   assign vld_out  = vld_ff[Q_W-1];
   assign quo_out  = quo_ff[Q_W-1];
   assign side_out = side_ff[Q_W-1];

endmodule

// ----- rtl/core/vector_refraction.sv -----
// ----------------------------------------------------------------------------
// vector_refraction
// refracts a direction vector at a surface by Snell's law, fully pipelined
// ----------------------------------------------------------------------------
// Usage
//  req channel: one transfer carries an incident vector (Q3.12, any length),
//  a unit normal (Q1.14) and an index ratio (unsigned Q4.12).
//  rsp channel: one transfer per request, in order; tuser is the refract
//  flag and tdata the refracted direction in Q1.14, saturated. On total
//  internal reflection or a zero incident vector the flag is low and the
//  vector is zero.
//  Throughput: one item per cycle while rsp_tready keeps the output moving.
//  Stages between request and response include the 31-stage length root,
//  the FRAC_BITS+2 stage divider and the FRAC_BITS+1 stage discriminant root.
//  Stall: the whole pipeline holds while a response waits and rsp_tready is
//  low; req_tready is low then, and nothing is lost or repeated. Bubbles
//  move forward while the output register is empty.
//  Reset: synchronous, clears all stage valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module vector_refraction
   import vref_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // inc_x, inc_y, inc_z, norm_x, norm_y, norm_z, eta_ratio
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x, out_y, out_z
   output logic [47:0]  rsp_tdata,
   // refracts
   output logic         rsp_tuser
);

   localparam int F    = FRAC_BITS;
   localparam int NW   = F + 32;
   localparam int QW   = F + 2;
   localparam int UW   = F + 2;
   localparam int PW   = F + 18;
   localparam int DTW  = F + 2;
   localparam int DDW  = 2 * F + 4;
   localparam int NDW  = F + 18;
   localparam int SW   = F + 2;
   localparam int TGW  = F + 5;
   localparam int ESW  = F + 19;
   localparam int ETW  = F + 22;
   localparam int TW   = F + 7;
   localparam int AW   = F + 10;
   localparam int E2W  = F + 24;
   localparam int DW   = F + 10;
   localparam int IN2W = 2 * F + 2;
   localparam int SQW  = F + 1;
   localparam int BW   = F + 18;
   localparam int OW   = F + 11;
   localparam int UP   = (F < NORM_FRAC) ? NORM_FRAC - F : 0;
   localparam int DN   = (F >= NORM_FRAC) ? F - NORM_FRAC : 0;
   localparam int SIDE1_W = 1 + 6 * FIELD_W + FIELD_W;
   localparam int SIDE2_W = 1 + NUM_AXES + 3 * FIELD_W + FIELD_W;
   localparam int SIDE3_W = 1 + NUM_AXES * AW + NUM_AXES * FIELD_W;
   localparam logic signed [63:0] ONE = 64'sd1 <<< F;

   typedef struct packed {
      logic [NUM_AXES-1:0][FIELD_W-1:0] n;
      logic [FIELD_W-1:0]               eta;
      logic                             zero;
   } carry_type;

   logic en;

   // front stages
   logic signed [FIELD_W-1:0] v1_ff [NUM_AXES];
   logic [NUM_AXES-1:0][FIELD_W-1:0] v2_ff, v3_ff;
   logic [NUM_AXES-1:0][FIELD_W-1:0] n1_ff, n2_ff, n3_ff;
   logic [FIELD_W-1:0] eta1_ff, eta2_ff, eta3_ff;
   logic [2*FIELD_W-2:0] sq2_ff [NUM_AXES];
   logic [L2_W-1:0] l2_ff;
   logic [2:0] vld_a_ff;

   // length root
   logic [SIDE1_W-1:0] side1_in, side1_out;
   logic               r1_vld;
   logic [LEN_W-1:0]   len_out;

   // divider
   logic [NUM_AXES-1:0][NW-1:0] num_in, num_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [SIDE2_W-1:0] side2_in, side2_ff, side2_out;
   logic               vld4_ff;
   logic               d_vld;
   logic [NUM_AXES-1:0][QW-1:0] quo_out;

   // refraction stages
   logic [8:0] vld_b_ff;
   carry_type c5_ff, c6_ff, c7_ff, c8_ff, c9_ff, c10_ff, c11_ff, c12_ff, c13_ff;
   logic signed [UW-1:0]  u_in [NUM_AXES];
   logic signed [UW-1:0]  u5_ff [NUM_AXES];
   logic signed [UW-1:0]  u6_ff [NUM_AXES];
   logic signed [UW-1:0]  u7_ff [NUM_AXES];
   logic signed [UW-1:0]  u8_ff [NUM_AXES];
   logic signed [PW-1:0]  p_in [NUM_AXES];
   logic signed [PW-1:0]  p6_ff [NUM_AXES];
   logic signed [DTW-1:0] dt_in, dt7_ff;
   logic signed [DDW-1:0] dd_in, dd8_ff;
   logic signed [NDW-1:0] nd_in [NUM_AXES];
   logic signed [NDW-1:0] nd8_ff [NUM_AXES];
   logic signed [SW-1:0]  s_in, s9_ff;
   logic signed [TGW-1:0] tg_in [NUM_AXES];
   logic signed [TGW-1:0] tg9_ff [NUM_AXES];
   logic signed [ESW-1:0] es_in, es10_ff;
   logic signed [ETW-1:0] et_in [NUM_AXES];
   logic signed [ETW-1:0] et10_ff [NUM_AXES];
   logic signed [TW-1:0]  t_in, t11_ff;
   logic signed [AW-1:0]  a_in [NUM_AXES];
   logic signed [AW-1:0]  a11_ff [NUM_AXES];
   logic signed [AW-1:0]  a12_ff [NUM_AXES];
   logic signed [AW-1:0]  a13_ff [NUM_AXES];
   logic signed [E2W-1:0] e2_in, e212_ff;
   logic signed [DW-1:0]  disc_in, disc13_ff;
   logic signed [FIELD_W:0] eta_s [13:10];

   // discriminant root
   logic                ok13;
   logic [IN2W-1:0]     x2_in;
   logic [SIDE3_W-1:0]  side3_in, side3_out;
   logic                r2_vld;
   logic [SQW-1:0]      sq_out;

   // tail stages
   logic [1:0] vld_c_ff;
   logic signed [BW-1:0] b_in [NUM_AXES];
   logic signed [BW-1:0] b14_ff [NUM_AXES];
   logic signed [AW-1:0] a14_ff [NUM_AXES];
   logic ok14_ff, ok15_ff;
   logic signed [OW-1:0] o_in [NUM_AXES];
   logic signed [OW-1:0] o15_ff [NUM_AXES];
   logic [NUM_AXES-1:0][FIELD_W-1:0] out_in;
   logic [NUM_AXES-1:0][FIELD_W-1:0] out_data_ff;
   logic out_flag_ff;
   logic out_vld_ff;

   // global advance: the output register is free or being taken
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   // stages 1 to 3: capture, squares, squared length
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            v1_ff[i] <= $signed(req_tdata[FIELD_W*i +: FIELD_W]);
            n1_ff[i] <= req_tdata[FIELD_W*(NUM_AXES+i) +: FIELD_W];
            sq2_ff[i] <= (2*FIELD_W-1)'(v1_ff[i] * v1_ff[i]);
            v2_ff[i] <= v1_ff[i];
         end
         eta1_ff <= req_tdata[FIELD_W*2*NUM_AXES +: FIELD_W];
         n2_ff   <= n1_ff;
         eta2_ff <= eta1_ff;
         l2_ff   <= L2_W'(sq2_ff[0]) + L2_W'(sq2_ff[1]) + L2_W'(sq2_ff[2]);
         v3_ff   <= v2_ff;
         n3_ff   <= n2_ff;
         eta3_ff <= eta2_ff;
      end
   end

   assign side1_in = {eta3_ff, n3_ff, v3_ff, (l2_ff == '0)};

   vref_sqrt #(
      .IN_W   (L2_W + L2_SHIFT),
      .SIDE_W (SIDE1_W)
   ) u_len_root (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (vld_a_ff[2]),
      .x_in     ({l2_ff, {L2_SHIFT{1'b0}}}),
      .side_in  (side1_in),
      .vld_out  (r1_vld),
      .root_out (len_out),
      .side_out (side1_out)
   );

   // stage 4: rounded dividends from magnitudes and length
   always_comb begin
      logic signed [FIELD_W-1:0] vc;
      logic [63:0] m;
      for (int i = 0; i < NUM_AXES; i++) begin
         vc = $signed(side1_out[1 + FIELD_W*i +: FIELD_W]);
         m = vc[FIELD_W-1] ? 64'(-64'(vc)) : 64'(64'(vc));
         num_in[i] = NW'((m << (F + LEN_FRAC)) + 64'(len_out >> 1));
         side2_in[1 + i] = vc[FIELD_W-1];
      end
      side2_in[0] = side1_out[0];
      side2_in[SIDE2_W-1 -: 4*FIELD_W] = side1_out[SIDE1_W-1 -: 4*FIELD_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= num_in;
         len_ff   <= len_out;
         side2_ff <= side2_in;
      end
   end

   vref_div #(
      .NUM_W  (NW),
      .DEN_W  (LEN_W),
      .Q_W    (QW),
      .SIDE_W (SIDE2_W)
   ) u_norm_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (vld4_ff),
      .num_in   (num_ff),
      .den_in   (len_ff),
      .side_in  (side2_ff),
      .vld_out  (d_vld),
      .quo_out  (quo_out),
      .side_out (side2_out)
   );

   // per-stage eta as a signed operand
   assign eta_s[10] = $signed({1'b0, c9_ff.eta});
   assign eta_s[11] = $signed({1'b0, c10_ff.eta});
   assign eta_s[12] = $signed({1'b0, c11_ff.eta});
   assign eta_s[13] = $signed({1'b0, c12_ff.eta});

   // refraction arithmetic between registers
   always_comb begin
      logic [QW-1:0] qc;
      logic signed [63:0] acc;
      for (int i = 0; i < NUM_AXES; i++) begin
         // unit vector component, limited to one
         qc = (quo_out[i] > QW'(ONE)) ? QW'(ONE) : quo_out[i];
         u_in[i] = side2_out[1 + i] ? -$signed(qc) : $signed(qc);
         p_in[i]  = u5_ff[i] * $signed(c5_ff.n[i]);
         nd_in[i] = $signed(c7_ff.n[i]) * dt7_ff;
         tg_in[i] = TGW'(64'(u8_ff[i]) - rnd_shr(64'(nd8_ff[i]), NORM_FRAC));
         et_in[i] = eta_s[10] * tg9_ff[i];
         a_in[i]  = AW'(rnd_shr(64'(et10_ff[i]), ETA_FRAC));
      end
      // dot product, clamped to the range minus one to one
      acc = rnd_shr(64'(p6_ff[0]) + 64'(p6_ff[1]) + 64'(p6_ff[2]), NORM_FRAC);
      if (acc > ONE) begin
         acc = ONE;
      end else if (acc < -ONE) begin
         acc = -ONE;
      end
      dt_in   = DTW'(acc);
      dd_in   = dt7_ff * dt7_ff;
      s_in    = SW'(ONE - rnd_shr(64'(dd8_ff), F));
      es_in   = eta_s[10] * s9_ff;
      t_in    = TW'(rnd_shr(64'(es10_ff), ETA_FRAC));
      e2_in   = eta_s[12] * t11_ff;
      disc_in = DW'(ONE - rnd_shr(64'(e212_ff), ETA_FRAC));
   end

   // stages 5 to 13
   always_ff @(posedge clock) begin
      if (en) begin
         c5_ff  <= '{n: side2_out[SIDE2_W-FIELD_W-1 -: 3*FIELD_W],
                     eta: side2_out[SIDE2_W-1 -: FIELD_W], zero: side2_out[0]};
         c6_ff  <= c5_ff;
         c7_ff  <= c6_ff;
         c8_ff  <= c7_ff;
         c9_ff  <= c8_ff;
         c10_ff <= c9_ff;
         c11_ff <= c10_ff;
         c12_ff <= c11_ff;
         c13_ff <= c12_ff;
         for (int i = 0; i < NUM_AXES; i++) begin
            u5_ff[i]   <= u_in[i];
            u6_ff[i]   <= u5_ff[i];
            p6_ff[i]   <= p_in[i];
            u7_ff[i]   <= u6_ff[i];
            u8_ff[i]   <= u7_ff[i];
            nd8_ff[i]  <= nd_in[i];
            tg9_ff[i]  <= tg_in[i];
            et10_ff[i] <= et_in[i];
            a11_ff[i]  <= a_in[i];
            a12_ff[i]  <= a11_ff[i];
            a13_ff[i]  <= a12_ff[i];
         end
         dt7_ff    <= dt_in;
         dd8_ff    <= dd_in;
         s9_ff     <= s_in;
         es10_ff   <= es_in;
         t11_ff    <= t_in;
         e212_ff   <= e2_in;
         disc13_ff <= disc_in;
      end
   end

   // discriminant root input, zero unless the ray refracts
   assign ok13     = (disc13_ff > 0) && !c13_ff.zero;
   assign x2_in    = ok13 ? (IN2W'(disc13_ff[F:0]) << F) : '0;
   assign side3_in = {c13_ff.n, a13_ff[2], a13_ff[1], a13_ff[0], ok13};

   // eta is only needed up to the discriminant
   logic unused_eta;
   assign unused_eta = ^{c13_ff.eta, eta_s[11], eta_s[13]};

   vref_sqrt #(
      .IN_W   (IN2W),
      .SIDE_W (SIDE3_W)
   ) u_disc_root (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (vld_b_ff[8]),
      .x_in     (x2_in),
      .side_in  (side3_in),
      .vld_out  (r2_vld),
      .root_out (sq_out),
      .side_out (side3_out)
   );

   // tail: normal term, combine, convert and saturate
   always_comb begin
      logic signed [63:0] r;
      for (int i = 0; i < NUM_AXES; i++) begin
         b_in[i] = $signed(side3_out[1 + NUM_AXES*AW + FIELD_W*i +: FIELD_W])
                 * $signed({1'b0, sq_out});
         o_in[i] = OW'(64'(a14_ff[i]) - rnd_shr(64'(b14_ff[i]), NORM_FRAC));
         r = rnd_shr(64'(o15_ff[i]) <<< UP, DN);
         if (r > 64'sd32767) begin
            r = 64'sd32767;
         end else if (r < -64'sd32768) begin
            r = -64'sd32768;
         end
         out_in[i] = ok15_ff ? FIELD_W'(r) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            b14_ff[i] <= b_in[i];
            a14_ff[i] <= $signed(side3_out[1 + AW*i +: AW]);
            o15_ff[i] <= o_in[i];
         end
         ok14_ff     <= side3_out[0];
         ok15_ff     <= ok14_ff;
         out_data_ff <= out_in;
         out_flag_ff <= ok15_ff;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff   <= '0;
         vld4_ff    <= 1'b0;
         vld_b_ff   <= '0;
         vld_c_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff   <= {vld_a_ff[1:0], req_tvalid};
         vld4_ff    <= r1_vld;
         vld_b_ff   <= {vld_b_ff[7:0], d_vld};
         vld_c_ff   <= {vld_c_ff[0], r2_vld};
         out_vld_ff <= vld_c_ff[1];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_flag_ff;

`ifndef SYNTH
   // a result without refraction carries a zero vector
   a_zero_when_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("nonzero vector without refraction");

   // the x component of the normalized vector stays within plus or minus one
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      vld_b_ff[0] |-> (64'(u5_ff[0]) <= ONE) && (64'(u5_ff[0]) >= -ONE))
      else $error("normalized component out of range");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // while the pipeline enable is low, the tail refract flag and tail valid bits hold
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(ok15_ff) && $stable(vld_c_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule
